// ===== rtl/rmap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmap_pkg: shared definitions for the rate-monotonic admission partitioner
// Field widths, command/status/policy codes and the task table entry layout.
// ----------------------------------------------------------------------------
package rmap_pkg;

    // default sizing
    localparam int NUM_CPUS_DEF      = 4;
    localparam int TASKS_PER_CPU_DEF = 16;

    // field widths
    localparam int TASK_W    = 22;
    localparam int TIME_W    = 30;
    localparam int CPU_SEL_W = 3;
    localparam int PCT_W     = 7;
    localparam int STATUS_W  = 3;
    localparam int ACPU_W    = 2;
    localparam int POLICY_W  = 2;
    // dividend width of the shared divider: 100 * C fits in 37 bits
    localparam int DIVD_W    = 37;

    localparam int FULL_PERCENT = 100;

    localparam logic [CPU_SEL_W-1:0] AUTO_CPU = 3'd4;

    // commands
    localparam logic CMD_RESERVE = 1'b0;
    localparam logic CMD_CANCEL  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_SCHED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_RESERVED = 3'd4;

    // fit policies
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd1;
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd2;
    localparam logic [POLICY_W-1:0] POL_RSVD  = 2'd3;

    // one task table entry
    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TIME_W-1:0] compute;
        logic [TIME_W-1:0] period;
        logic [PCT_W-1:0]  percent;
    } t_entry;

endpackage

// ===== rtl/rmap_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmap interfaces: request, response and configuration channels
// Each channel carries valid, ready and its payload.
// ----------------------------------------------------------------------------
interface rmap_req_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [rmap_pkg::TASK_W-1:0]     task_id;
    logic [rmap_pkg::TIME_W-1:0]     compute_ns;
    logic [rmap_pkg::TIME_W-1:0]     period_ns;
    logic [rmap_pkg::CPU_SEL_W-1:0]  target_cpu;

    modport source (output valid, cmd, task_id, compute_ns, period_ns, target_cpu,
                    input ready);
    modport sink   (input valid, cmd, task_id, compute_ns, period_ns, target_cpu,
                    output ready);
endinterface

interface rmap_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [rmap_pkg::STATUS_W-1:0]   status;
    logic [rmap_pkg::ACPU_W-1:0]     assigned_cpu;

    modport source (output valid, status, assigned_cpu, input ready);
    modport sink   (input valid, status, assigned_cpu, output ready);
endinterface

interface rmap_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rmap_pkg::POLICY_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/rm_admission_partitioner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rm_admission_partitioner: rate-monotonic admission control over processors
// Reserves and cancels periodic tasks in per-processor tables sorted by period,
// checking each placement by response-time iteration on a shared divider.
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents                                   | accepted when
//  ---------+-----+-------------------------------------------------+--------------
//  i_req    | in  | cmd, task_id, compute_ns, period_ns, target_cpu | valid & ready
//  o_rsp    | out | status, assigned_cpu                            | valid & ready
//  i_cfg    | in  | data (fit_policy)                               | valid & ready
//
//  One request at a time; i_req.ready is high only while the controller idles.
//  Per request: a utilization divide, an id scan over the table entries, a
//  response-time iteration with one divide per interfering task (on the shared
//  37-bit divider), and moving the table entries behind the slot on commit.
//  Reset clears the task counts and fit_policy; no clearing pass is needed.
//  A response waiting on o_rsp.ready stalls only the finish of the next one.
// ----------------------------------------------------------------------------
module rm_admission_partitioner #(
    parameter int NUM_CPUS      = rmap_pkg::NUM_CPUS_DEF,
    parameter int TASKS_PER_CPU = rmap_pkg::TASKS_PER_CPU_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmap_cfg_if.sink    i_cfg,
    rmap_req_if.sink    i_req,
    rmap_rsp_if.source  o_rsp
);

    localparam int SLOTS   = NUM_CPUS * TASKS_PER_CPU;
    localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int CNT_W   = $clog2(TASKS_PER_CPU + 1);
    localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UTIL_W  = $clog2((TASKS_PER_CPU + 1) * rmap_pkg::FULL_PERCENT);
    localparam int UTL1_W  = UTIL_W + 1;
    localparam int ENT_W   = $bits(rmap_pkg::t_entry);
    localparam int DIV_W   = rmap_pkg::DIVD_W;
    localparam int DCNT_W  = $clog2(DIV_W + 1);
    localparam int TW      = rmap_pkg::TIME_W;
    localparam int PROD_W  = 2 * TW + 1;

    typedef enum logic [4:0] {
        S_IDLE, S_PCT_WAIT, S_SCAN_INIT, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END,
        S_REM_RD, S_REM_WR, S_PICK_INIT, S_PICK, S_CHOOSE, S_TRY,
        S_TK_RD, S_TK_LD, S_IT_START, S_J_RD, S_J_LD, S_J_DIV, S_J_ACC,
        S_IT_END, S_INS_RD, S_INS_WR, S_FAIL, S_DONE
    } t_state;

    t_state r_state;

    // latched request
    logic                              r_cmd;
    logic [rmap_pkg::TASK_W-1:0]       r_id;
    logic [TW-1:0]                     r_cn;
    logic [TW-1:0]                     r_tn;
    logic [rmap_pkg::CPU_SEL_W-1:0]    r_tgt;
    logic                              r_auto;
    logic [rmap_pkg::PCT_W-1:0]        r_pct;

    // per-processor bookkeeping
    logic [CNT_W-1:0]  r_cnt  [NUM_CPUS];
    logic [UTIL_W-1:0] r_util [NUM_CPUS];
    logic [CNT_W-1:0]  r_pos  [NUM_CPUS];

    // walk state
    logic [CPU_W-1:0]  r_cpu;
    logic [CNT_W-1:0]  r_k;
    logic [CNT_W-1:0]  r_vk;
    logic [CNT_W-1:0]  r_j;
    logic              r_vnew;

    // processor choice
    logic [NUM_CPUS-1:0] r_tried;
    logic [CPU_W-1:0]    r_pi;
    logic                r_have;
    logic [CPU_W-1:0]    r_best;
    logic [UTIL_W-1:0]   r_bu;

    // response-time iteration
    logic [TW-1:0]     r_t;
    logic [TW-1:0]     r_c;
    logic [TW-1:0]     r_r;
    logic [TW:0]       r_sum;
    logic [TW-1:0]     r_jc;
    logic [PROD_W-1:0] r_prod;

    // result and response register
    logic [rmap_pkg::STATUS_W-1:0] r_st;
    logic [rmap_pkg::ACPU_W-1:0]   r_ac;
    logic                          r_rsp_valid;
    logic [rmap_pkg::STATUS_W-1:0] r_rsp_status;
    logic [rmap_pkg::ACPU_W-1:0]   r_rsp_cpu;

    // configuration
    logic [rmap_pkg::POLICY_W-1:0] r_policy;

    // shared divider
    logic              r_div_busy;
    logic [DCNT_W-1:0] r_div_cnt;
    logic [TW-1:0]     r_div_rem;
    logic [DIV_W-1:0]  r_div_quo;
    logic [TW-1:0]     r_div_dvs;

    // RAM port
    logic              w_ram_we;
    logic [ADDR_W-1:0] w_ram_waddr;
    logic [ENT_W-1:0]  w_ram_wdata;
    logic              w_ram_re;
    logic [ADDR_W-1:0] w_ram_raddr;
    logic [ENT_W-1:0]  w_ram_rdata;

    // combinational helpers
    logic                 w_accept;
    logic                 w_req_bad;
    logic [CNT_W-1:0]     w_cur_cnt;
    logic [CNT_W-1:0]     w_cur_pos;
    logic [UTIL_W-1:0]    w_cur_util;
    logic [ADDR_W-1:0]    w_base;
    rmap_pkg::t_entry     w_rd_ent;
    rmap_pkg::t_entry     w_new;
    rmap_pkg::t_entry     w_vent;
    logic [ADDR_W-1:0]    w_vk_addr;
    logic [ADDR_W-1:0]    w_j_addr;
    logic [CNT_W-1:0]     w_k_inc;
    logic                 w_j_go;
    logic                 w_div_load;
    logic [DIV_W-1:0]     w_div_dvd;
    logic [TW-1:0]        w_div_dvs;
    logic [TW:0]          w_div_sh;
    logic [TW+1:0]        w_div_diff;
    logic [TW:0]          w_qp1;
    logic [TW:0]          w_sum_new;
    logic [TW:0]          w_rn;
    logic [UTL1_W-1:0]    w_fit_sum;
    logic                 w_over;
    logic                 w_full;
    logic [UTIL_W-1:0]    w_pu;
    logic                 w_take;
    logic                 w_pi_last;
    logic                 w_scan_last;
    logic                 w_rsp_load;

    // ------------------------------------------------------------------
    // task table
    // ------------------------------------------------------------------
    rmap_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // ------------------------------------------------------------------
    // request decode and shared terms
    // ------------------------------------------------------------------
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_req_bad   = (i_req.compute_ns == '0) || (i_req.period_ns == '0) ||
                         (i_req.compute_ns >= i_req.period_ns) ||
                         ((i_req.target_cpu != rmap_pkg::AUTO_CPU) &&
                          (int'(i_req.target_cpu) >= NUM_CPUS));

    assign w_cur_cnt  = r_cnt[r_cpu];
    assign w_cur_pos  = r_pos[r_cpu];
    assign w_cur_util = r_util[r_cpu];
    assign w_base     = ADDR_W'(r_cpu) * ADDR_W'(TASKS_PER_CPU);
    assign w_rd_ent   = rmap_pkg::t_entry'(w_ram_rdata);
    assign w_new      = '{task_id: r_id, compute: r_cn, period: r_tn, percent: r_pct};
    assign w_vent     = r_vnew ? w_new : w_rd_ent;
    assign w_k_inc    = r_k + CNT_W'(1);

    // map a slot of the table with the new task inserted onto the stored table
    assign w_vk_addr = w_base + ADDR_W'((r_vk < w_cur_pos) ? r_vk : (r_vk - CNT_W'(1)));
    assign w_j_addr  = w_base + ADDR_W'((r_j < w_cur_pos) ? r_j : (r_j - CNT_W'(1)));

    // interfering task found: start ceil division of R by its period
    assign w_j_go     = (r_state == S_J_LD) && (w_vent.period < r_t);
    assign w_div_load = (w_accept && (i_req.cmd == rmap_pkg::CMD_RESERVE) && !w_req_bad) ||
                        w_j_go;
    assign w_div_dvd  = w_j_go ? DIV_W'(r_r - TW'(1))
                               : DIV_W'(i_req.compute_ns) * DIV_W'(rmap_pkg::FULL_PERCENT);
    assign w_div_dvs  = w_j_go ? w_vent.period : i_req.period_ns;

    assign w_qp1     = r_div_quo[TW:0] + (TW + 1)'(1);
    assign w_sum_new = r_sum + r_prod[TW:0];
    assign w_rn      = {1'b0, r_c} + r_sum;

    assign w_fit_sum = UTL1_W'(w_cur_util) + UTL1_W'(r_pct);
    assign w_over    = w_fit_sum > UTL1_W'(rmap_pkg::FULL_PERCENT);
    assign w_full    = w_cur_cnt >= CNT_W'(TASKS_PER_CPU);

    // policy order: worst fit takes lowest first, best fit highest (later on ties), first fit lowest index
    assign w_pu      = r_util[r_pi];
    assign w_take    = !r_tried[r_pi] &&
                       (!r_have ||
                        ((r_policy == rmap_pkg::POL_WORST) && (w_pu < r_bu)) ||
                        ((r_policy == rmap_pkg::POL_BEST) && (w_pu >= r_bu)));
    assign w_pi_last   = (r_pi == CPU_W'(NUM_CPUS - 1));
    assign w_scan_last = (r_cpu == CPU_W'(NUM_CPUS - 1));

    // response register takes a new beat when empty or being drained
    assign w_rsp_load  = (r_state == S_DONE) && (!r_rsp_valid || o_rsp.ready);

    // ------------------------------------------------------------------
    // table access per state
    // ------------------------------------------------------------------
    always_comb begin
        w_ram_re    = 1'b0;
        w_ram_raddr = '0;
        w_ram_we    = 1'b0;
        w_ram_waddr = '0;
        w_ram_wdata = '0;
        case (r_state)
            S_SCAN_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_base + ADDR_W'(r_k);
            end
            S_TK_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_vk_addr;
            end
            S_J_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_j_addr;
            end
            S_REM_RD: begin
                w_ram_re    = 1'b1;
                w_ram_raddr = w_base + ADDR_W'(w_k_inc);
            end
            S_INS_RD: begin
                if (r_k > w_cur_pos) begin
                    w_ram_re    = 1'b1;
                    w_ram_raddr = w_base + ADDR_W'(r_k - CNT_W'(1));
                end else begin
                    w_ram_we    = 1'b1;
                    w_ram_waddr = w_base + ADDR_W'(r_k);
                    w_ram_wdata = w_new;
                end
            end
            S_REM_WR, S_INS_WR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = w_base + ADDR_W'(r_k);
                w_ram_wdata = w_ram_rdata;
            end
            default: begin
                w_ram_re = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // shared restoring divider, one quotient bit per cycle
    // ------------------------------------------------------------------
    assign w_div_sh   = {r_div_rem, r_div_quo[DIV_W-1]};
    assign w_div_diff = {1'b0, w_div_sh} - {2'b00, r_div_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b0;
        end else if (w_div_load) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= DCNT_W'(DIV_W);
            r_div_quo  <= w_div_dvd;
            r_div_rem  <= '0;
            r_div_dvs  <= w_div_dvs;
        end else if (r_div_busy) begin
            if (!w_div_diff[TW+1]) begin
                r_div_rem <= w_div_diff[TW-1:0];
                r_div_quo <= {r_div_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_div_rem <= w_div_sh[TW-1:0];
                r_div_quo <= {r_div_quo[DIV_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt - DCNT_W'(1);
            if (r_div_cnt == DCNT_W'(1)) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // fit policy register; a write of the reserved code is dropped
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= rmap_pkg::POL_BEST;
        end else if (i_cfg.valid && (i_cfg.data != rmap_pkg::POL_RSVD)) begin
            r_policy <= i_cfg.data;
        end
    end

    // ------------------------------------------------------------------
    // controller
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            // load a new response beat, else retire a delivered one
            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd  <= i_req.cmd;
                        r_id   <= i_req.task_id;
                        r_cn   <= i_req.compute_ns;
                        r_tn   <= i_req.period_ns;
                        r_tgt  <= i_req.target_cpu;
                        r_auto <= (i_req.target_cpu == rmap_pkg::AUTO_CPU);
                        if (i_req.cmd == rmap_pkg::CMD_CANCEL) begin
                            r_state <= S_SCAN_INIT;
                        end else if (w_req_bad) begin
                            r_st    <= rmap_pkg::ST_INVALID;
                            r_ac    <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PCT_WAIT;
                        end
                    end
                end
                S_PCT_WAIT: begin
                    if (!r_div_busy) begin
                        r_pct   <= r_div_quo[rmap_pkg::PCT_W-1:0];
                        r_state <= S_SCAN_INIT;
                    end
                end
                S_SCAN_INIT: begin
                    r_cpu <= '0;
                    r_k   <= '0;
                    for (int c = 0; c < NUM_CPUS; c++) begin
                        r_util[c] <= '0;
                        r_pos[c]  <= r_cnt[c];
                    end
                    r_state <= S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    if (r_k >= w_cur_cnt) begin
                        if (w_scan_last) begin
                            r_state <= S_SCAN_END;
                        end else begin
                            r_cpu <= r_cpu + CPU_W'(1);
                            r_k   <= '0;
                        end
                    end else begin
                        r_state <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (w_rd_ent.task_id == r_id) begin
                        if (r_cmd == rmap_pkg::CMD_CANCEL) begin
                            r_state <= S_REM_RD;
                        end else begin
                            r_st    <= rmap_pkg::ST_ALREADY;
                            r_ac    <= '0;
                            r_state <= S_DONE;
                        end
                    end else begin
                        // sum utilization, note first slot with a longer period
                        r_util[r_cpu] <= w_cur_util + UTIL_W'(w_rd_ent.percent);
                        if ((r_tn < w_rd_ent.period) && (w_cur_pos == w_cur_cnt)) begin
                            r_pos[r_cpu] <= r_k;
                        end
                        r_k     <= w_k_inc;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_END: begin
                    if (r_cmd == rmap_pkg::CMD_CANCEL) begin
                        r_st    <= rmap_pkg::ST_NOT_RESERVED;
                        r_ac    <= '0;
                        r_state <= S_DONE;
                    end else if (r_auto) begin
                        r_tried <= '0;
                        r_state <= S_PICK_INIT;
                    end else begin
                        r_cpu   <= CPU_W'(r_tgt);
                        r_state <= S_TRY;
                    end
                end
                S_REM_RD: begin
                    if (w_k_inc < w_cur_cnt) begin
                        r_state <= S_REM_WR;
                    end else begin
                        r_cnt[r_cpu] <= w_cur_cnt - CNT_W'(1);
                        r_st         <= rmap_pkg::ST_DONE;
                        r_ac         <= rmap_pkg::ACPU_W'(r_cpu);
                        r_state      <= S_DONE;
                    end
                end
                S_REM_WR: begin
                    r_k     <= w_k_inc;
                    r_state <= S_REM_RD;
                end
                S_PICK_INIT: begin
                    r_pi    <= '0;
                    r_have  <= 1'b0;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (w_take) begin
                        r_have <= 1'b1;
                        r_best <= r_pi;
                        r_bu   <= w_pu;
                    end
                    if (w_pi_last) begin
                        r_state <= S_CHOOSE;
                    end else begin
                        r_pi <= r_pi + CPU_W'(1);
                    end
                end
                S_CHOOSE: begin
                    if (!r_have) begin
                        r_st    <= rmap_pkg::ST_NOT_SCHED;
                        r_ac    <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_tried[r_best] <= 1'b1;
                        r_cpu           <= r_best;
                        r_state         <= S_TRY;
                    end
                end
                S_TRY: begin
                    if (w_full || w_over) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_vk    <= '0;
                        r_state <= S_TK_RD;
                    end
                end
                S_TK_RD: begin
                    if (r_vk > w_cur_cnt) begin
                        // every task passed: open a slot and insert
                        r_k     <= w_cur_cnt;
                        r_state <= S_INS_RD;
                    end else begin
                        r_vnew  <= (r_vk == w_cur_pos);
                        r_state <= S_TK_LD;
                    end
                end
                S_TK_LD: begin
                    r_t     <= w_vent.period;
                    r_c     <= w_vent.compute;
                    r_r     <= w_vent.compute;
                    r_state <= S_IT_START;
                end
                S_IT_START: begin
                    r_sum   <= '0;
                    r_j     <= '0;
                    r_state <= S_J_RD;
                end
                S_J_RD: begin
                    if (r_j >= r_vk) begin
                        r_state <= S_IT_END;
                    end else begin
                        r_vnew  <= (r_j == w_cur_pos);
                        r_state <= S_J_LD;
                    end
                end
                S_J_LD: begin
                    if (w_j_go) begin
                        r_jc    <= w_vent.compute;
                        r_state <= S_J_DIV;
                    end else begin
                        r_state <= S_IT_END;
                    end
                end
                S_J_DIV: begin
                    if (!r_div_busy) begin
                        r_prod  <= w_qp1 * r_jc;
                        r_state <= S_J_ACC;
                    end
                end
                S_J_ACC: begin
                    if ((r_prod > PROD_W'(r_t)) || (w_sum_new > {1'b0, r_t})) begin
                        r_state <= S_FAIL;
                    end else begin
                        r_sum   <= w_sum_new;
                        r_j     <= r_j + CNT_W'(1);
                        r_state <= S_J_RD;
                    end
                end
                S_IT_END: begin
                    if (w_rn > {1'b0, r_t}) begin
                        r_state <= S_FAIL;
                    end else if (w_rn[TW-1:0] == r_r) begin
                        r_vk    <= r_vk + CNT_W'(1);
                        r_state <= S_TK_RD;
                    end else begin
                        r_r     <= w_rn[TW-1:0];
                        r_state <= S_IT_START;
                    end
                end
                S_INS_RD: begin
                    if (r_k > w_cur_pos) begin
                        r_state <= S_INS_WR;
                    end else begin
                        r_cnt[r_cpu] <= w_cur_cnt + CNT_W'(1);
                        r_st         <= rmap_pkg::ST_DONE;
                        r_ac         <= rmap_pkg::ACPU_W'(r_cpu);
                        r_state      <= S_DONE;
                    end
                end
                S_INS_WR: begin
                    r_k     <= r_k - CNT_W'(1);
                    r_state <= S_INS_RD;
                end
                S_FAIL: begin
                    if (r_auto) begin
                        r_state <= S_PICK_INIT;
                    end else begin
                        r_st    <= rmap_pkg::ST_NOT_SCHED;
                        r_ac    <= '0;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_rsp_load) begin
                        r_rsp_status <= r_st;
                        r_rsp_cpu    <= r_ac;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp_status;
    assign o_rsp.assigned_cpu = r_rsp_cpu;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_fail_cpu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != rmap_pkg::ST_DONE)) |-> (o_rsp.assigned_cpu == '0))
        else $error("failed response carries a processor number");

    a_div_no_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_load |-> !r_div_busy)
        else $error("divider loaded while busy");

    a_interferer_before: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_J_ACC) |-> (r_j < r_vk))
        else $error("interfering task not ahead of the task under test");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TRY) |-> (r_pct < rmap_pkg::PCT_W'(rmap_pkg::FULL_PERCENT)))
        else $error("task utilization percent out of range");

    for (genvar g = 0; g < NUM_CPUS; g++) begin : g_cnt_chk
        a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_cnt[g] <= CNT_W'(TASKS_PER_CPU))
            else $error("processor task count beyond table size");
    end

endmodule

// ===== rtl/rmap_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmap_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rmap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
